// File: rtl/core/run_length_encoder_capped_core_defines.svh
// assertion macros for the checker file
`ifndef RUN_LENGTH_ENCODER_CAPPED_CORE_DEFINES_SVH
`define RUN_LENGTH_ENCODER_CAPPED_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RLEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rlec same-cycle check failed");

// next-cycle implication, disabled while in reset
`define RLEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rlec next-cycle check failed");

`endif

// File: rtl/core/rlec_pkg.sv
package rlec_pkg;

  // field widths
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned TOTAL_W    = 17;
  localparam int unsigned IN_TDATA_W = 8;
  // count + code + total, padded to whole bytes
  localparam int unsigned RES_W       = COUNT_W + CODE_BITS + TOTAL_W;
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // run length cap and saturation limit of the run total
  localparam logic [COUNT_W-1:0] MAX_RUN   = COUNT_W'(65535);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // result queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // one result item
  typedef struct packed {
    logic [TOTAL_W-1:0]   total_runs;
    logic                 final_run;
    logic [CODE_BITS-1:0] run_code;
    logic [COUNT_W-1:0]   run_count;
  } run_t;

  // saturating increment of the run total
  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == TOTAL_MAX) ? TOTAL_MAX : v + TOTAL_W'(1);
  endfunction

endpackage

// File: rtl/core/run_length_encoder_capped_core.sv
// the results of an item are written into the result queue registers at its input transfer
// throughput: one block per cycle while the result queue has room; a final block
//   that also closes a run gives two results, written together, the second after the first
// input is ready while the four-entry result queue has room for two results
// reset clears the open run, the run total and the result queue
module run_length_encoder_capped_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rlec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] block_code
  input  logic                               s_axis_tlast,   // final_block
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rlec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [15:0] run_count,
                                                             // [23:16] run_code,
                                                             // [40:24] total_runs
  output logic                               m_axis_tlast    // final_run
);
  import rlec_pkg::*;

  logic                 have_q, have_d;
  logic [CODE_BITS-1:0] pcode_q, pcode_d;
  logic [COUNT_W-1:0]   pcount_q, pcount_d;
  logic [TOTAL_W-1:0]   runs_q, runs_d;

  logic                 in_xfer;
  logic [CODE_BITS-1:0] code;
  logic                 fin;
  logic                 extend;
  logic                 close;
  logic [TOTAL_W-1:0]   runs_after;
  logic [COUNT_W-1:0]   run_count_new;
  logic [CODE_BITS-1:0] run_code_new;
  run_t                 closed_run;
  run_t                 final_res;
  run_t                 wr_first;
  logic [1:0]           push_cnt;
  run_t                 rd_data;
  logic                 not_empty;
  logic [CNT_W-1:0]     fill;
  logic                 pop;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign code    = s_axis_tdata[CODE_BITS-1:0];
  assign fin     = s_axis_tlast;

  // run extend or close decision
  always_comb begin
    extend        = have_q && (pcode_q == code) && (pcount_q != MAX_RUN);
    close         = have_q && !extend;
    runs_after    = close ? sat_inc(runs_q) : runs_q;
    run_count_new = extend ? pcount_q + COUNT_W'(1) : COUNT_W'(1);
    run_code_new  = extend ? pcode_q : code;
  end

  // result items
  always_comb begin
    closed_run.run_count  = pcount_q;
    closed_run.run_code   = pcode_q;
    closed_run.final_run  = 1'b0;
    closed_run.total_runs = '0;
    final_res.run_count   = run_count_new;
    final_res.run_code    = run_code_new;
    final_res.final_run   = 1'b1;
    final_res.total_runs  = sat_inc(runs_after);
    wr_first              = close ? closed_run : final_res;
    push_cnt              = in_xfer ? (2'(close) + 2'(fin)) : 2'd0;
  end

  // next open run; a final block clears everything
  always_comb begin
    have_d   = have_q;
    pcode_d  = pcode_q;
    pcount_d = pcount_q;
    runs_d   = runs_q;
    if (in_xfer) begin
      if (fin) begin
        have_d   = 1'b0;
        pcode_d  = '0;
        pcount_d = '0;
        runs_d   = '0;
      end else begin
        have_d   = 1'b1;
        pcode_d  = run_code_new;
        pcount_d = run_count_new;
        runs_d   = runs_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      pcode_q  <= '0;
      pcount_q <= '0;
      runs_q   <= '0;
    end else begin
      have_q   <= have_d;
      pcode_q  <= pcode_d;
      pcount_q <= pcount_d;
      runs_q   <= runs_d;
    end
  end

  // result queue
  rlec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wr_first_i  (wr_first),
    .wr_second_i (final_res),
    .pop_i       (pop),
    .rd_data_o   (rd_data),
    .not_empty_o (not_empty),
    .count_o     (fill)
  );

  // handshakes and output packing
  assign pop           = not_empty && m_axis_tready;
  assign s_axis_tready = (fill <= CNT_W'(FIFO_DEPTH - 2));
  assign m_axis_tvalid = not_empty;
  assign m_axis_tlast  = rd_data.final_run;
  assign m_axis_tdata  = OUT_TDATA_W'({rd_data.total_runs, rd_data.run_code,
                                       rd_data.run_count});

endmodule

// File: rtl/core/rlec_fifo.sv
module rlec_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [1:0]                  push_cnt_i,  // results written this cycle, 0 to 2
  input  rlec_pkg::run_t              wr_first_i,
  input  rlec_pkg::run_t              wr_second_i,
  input  logic                        pop_i,
  output rlec_pkg::run_t              rd_data_o,
  output logic                        not_empty_o,
  output logic [rlec_pkg::CNT_W-1:0]  count_o
);
  import rlec_pkg::*;

  run_t             slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    count_d  = count_q + CNT_W'(push_cnt_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // up to two writes at consecutive slots
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      slot_q[wr_ptr_q] <= wr_first_i;
    end
    if (push_cnt_i == 2'd2) begin
      slot_q[wr_ptr_q + PTR_W'(1)] <= wr_second_i;
    end
  end

  assign rd_data_o   = slot_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

// File: rtl/core/rlec_checker.sv
`include "run_length_encoder_capped_core_defines.svh"

module rlec_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [rlec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                               m_axis_tlast
);
  import rlec_pkg::*;

  logic [COUNT_W-1:0]   out_count;
  logic [TOTAL_W-1:0]   out_total;
  logic                 pad_zero;
  logic                 in_xfer;
  logic                 out_stall;
  logic                 out_mid;
  logic                 out_final;
  logic [OUT_TDATA_W:0] out_beat;

  assign out_count = m_axis_tdata[COUNT_W-1:0];
  assign out_total = m_axis_tdata[COUNT_W+CODE_BITS +: TOTAL_W];
  assign pad_zero  = (m_axis_tdata[OUT_TDATA_W-1:RES_W] == '0);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_mid   = m_axis_tvalid && !m_axis_tlast;
  assign out_final = m_axis_tvalid && m_axis_tlast;
  assign out_beat  = {m_axis_tlast, m_axis_tdata};

  // a stalled result holds
  `RLEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_beat))
  // every run has at least one block
  `RLEC_ASSERT_IMPL(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid, out_count != '0)
  // only the final run carries the chunk total
  `RLEC_ASSERT_IMPL(a_total_only_final, clk_i, rst_ni, out_mid, out_total == '0)
  // a final run counts itself
  `RLEC_ASSERT_IMPL(a_total_final, clk_i, rst_ni, out_final, out_total != '0 && pad_zero)
  // an accepted final block makes a result valid on the next cycle
  `RLEC_ASSERT_NEXT(a_final_follows, clk_i, rst_ni, in_xfer && s_axis_tlast, m_axis_tvalid)

endmodule

bind run_length_encoder_capped_core rlec_checker u_rlec_checker (.*);

// File: test/rle_run_checker.sv
// watches both stream channels, predicts the runs of each block and compares
module rle_run_checker
  import rlec_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] block_code
  input  logic                   s_axis_tlast,   // final_block
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] run_count, [23:16] run_code,
                                                 // [40:24] total_runs
  input  logic                   m_axis_tlast,   // final_run
  output int unsigned            runs_due_o,
  output int unsigned            mismatches_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // predicted encoder state
  logic                 open_run;
  logic [CODE_BITS-1:0] open_code;
  logic [COUNT_W-1:0]   open_len;
  logic [TOTAL_W-1:0]   closed_runs;

  // runs still owed by the block, oldest first
  run_t        runs_due_q[$];
  run_t        want;
  int unsigned mismatches;

  // run total that stops at its all-ones value
  function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // one block in, zero to two runs out
  function automatic void encode_block(input logic [CODE_BITS-1:0] code, input logic last);
    run_t r;
    if (open_run && open_code == code && open_len != MAX_RUN) begin
      open_len = open_len + 1'b1;
    end else begin
      // a different code or a full run closes the open run
      if (open_run) begin
        r = '0;
        r.run_count = open_len;
        r.run_code  = open_code;
        runs_due_q  = {runs_due_q, r};
        closed_runs = bump_total(closed_runs);
      end
      open_run  = 1'b1;
      open_code = code;
      open_len  = COUNT_W'(1);
    end
    // flush the open run with the chunk total, then start a fresh chunk
    if (last) begin
      r = '0;
      r.run_count  = open_len;
      r.run_code   = open_code;
      r.final_run  = 1'b1;
      r.total_runs = bump_total(closed_runs);
      runs_due_q   = {runs_due_q, r};
      open_run    = 1'b0;
      open_code   = '0;
      open_len    = '0;
      closed_runs = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] exp_val);
    mismatches++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  // results are checked before the block of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_run    = 1'b0;
      open_code   = '0;
      open_len    = '0;
      closed_runs = '0;
      runs_due_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (runs_due_q.size() == 0) begin
          report_mismatch("run with none expected", m_axis_tdata, '0);
        end else begin
          want = runs_due_q.pop_front();
          if (m_axis_tdata[COUNT_W-1:0] !== want.run_count)
            report_mismatch("run_count", 48'(m_axis_tdata[COUNT_W-1:0]),
                            48'(want.run_count));
          if (m_axis_tdata[COUNT_W +: CODE_BITS] !== want.run_code)
            report_mismatch("run_code", 48'(m_axis_tdata[COUNT_W +: CODE_BITS]),
                            48'(want.run_code));
          if (m_axis_tlast !== want.final_run)
            report_mismatch("final_run", 48'(m_axis_tlast), 48'(want.final_run));
          if (m_axis_tdata[COUNT_W+CODE_BITS +: TOTAL_W] !== want.total_runs)
            report_mismatch("total_runs", 48'(m_axis_tdata[COUNT_W+CODE_BITS +: TOTAL_W]),
                            48'(want.total_runs));
          if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0)
            report_mismatch("padding", 48'(m_axis_tdata[OUT_TDATA_W-1:RES_W]), '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        encode_block(s_axis_tdata[CODE_BITS-1:0], s_axis_tlast);
    end
    runs_due_o   = runs_due_q.size();
    mismatches_o = mismatches;
  end

endmodule

// File: test/run_length_encoder_capped_core_tb.sv
module run_length_encoder_capped_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rlec_pkg::*;

  localparam int unsigned RANDOM_BLOCKS = 600;
  localparam int unsigned MAX_GAP       = 5;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned LIMIT_CYCLES  = 60000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] block_code
  logic                   s_axis_tlast  = 1'b0; // final_block
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [15:0] run_count, [23:16] run_code,
                                                // [40:24] total_runs
  logic                   m_axis_tlast;         // final_run

  int unsigned runs_due;
  int unsigned mismatches;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;

  always #1 clk_i = ~clk_i;

  run_length_encoder_capped_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  rle_run_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .runs_due_o    (runs_due),
    .mismatches_o  (mismatches)
  );

  // runaway guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // one block transfer, after an optional gap with tvalid low
  task automatic send_block(input logic [CODE_BITS-1:0] code, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // result side: stall a random number of cycles before each transfer
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // block stream
  initial begin
    int unsigned          sent;
    int unsigned          len;
    int unsigned          i;
    logic [CODE_BITS-1:0] code;
    logic                 last;
    bit                   noise;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-block chunks at both code extremes
    send_block(8'h00, 1'b1);
    send_block(8'hff, 1'b1);
    // final block that closes a run, so two runs from one block
    send_block(8'haa, 1'b0);
    send_block(8'haa, 1'b0);
    send_block(8'h55, 1'b1);
    // final block that extends the open run
    send_block(8'h00, 1'b0);
    send_block(8'hff, 1'b0);
    send_block(8'hff, 1'b1);
    // several runs in a row
    send_block(8'h0f, 1'b0);
    send_block(8'h0f, 1'b0);
    send_block(8'h0f, 1'b0);
    send_block(8'hf0, 1'b0);
    send_block(8'h01, 1'b1);

    // random chunks, mostly runs of repeated codes, some pure noise
    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      noise   = ($urandom_range(0, 4) == 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      code    = CODE_BITS'($urandom);
      for (i = 0; i < len; i++) begin
        if (noise) begin
          code = CODE_BITS'($urandom);
          last = ($urandom_range(0, 7) == 0);
        end else begin
          if ($urandom_range(0, 9) < 4)
            code = CODE_BITS'($urandom);
          last = (i == len - 1);
        end
        send_block(code, last);
        sent++;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then give a late extra run time to show up
    while (runs_due != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
